/* src/rco_pkg.sv */
// Shared types and constants for the rotated checker overlay.
`timescale 1ns / 1ps
`default_nettype none
package rco_pkg;

    localparam int FRAME_WIDTH_DEF  = 320;
    localparam int FRAME_HEIGHT_DEF = 200;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int OFFS_W   = 12;   // signed half-pixel offset
    localparam int TRIG_W   = 16;   // Q2.14
    localparam int PROD_W   = OFFS_W + TRIG_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int FRAC_W   = 15;   // scale of the rotated sums
    localparam int CELL_W   = SUM_W - FRAC_W;  // signed cell coordinate
    localparam int MAG_W    = CELL_W - 1;      // folded magnitude
    localparam int DIV_SPLIT = 6;              // bits done in the last divide stage

    typedef enum logic [2:0] {
        REG_COS_ANGLE       = 3'd0,
        REG_SIN_ANGLE       = 3'd1,
        REG_CELL_SIZE       = 3'd2,
        REG_FOREGROUND_BASE = 3'd3,
        REG_LIGHT_OFFSET    = 3'd4
    } t_reg_idx;

    localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] SIN_RESET = 16'sd0;
    localparam logic [7:0] CELL_RESET  = 8'd24;
    localparam logic [7:0] FG_RESET    = 8'd4;
    localparam logic [7:0] LIGHT_RESET = 8'd2;

    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
        logic [7:0] index_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] index_out;
        logic       on_light_cell;
    } t_pix_out;

endpackage
`default_nettype wire

/* src/rotated_checker_overlay.sv */
// Rotated checkerboard overlay, five-stage pipeline with APB register port.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+-----------------------
//  pixel in  | input     | i_valid / o_stall    | i_data  (t_pix_in)
//  pixel out | output    | o_valid / i_stall    | o_data  (t_pix_out)
//  registers | input     | APB psel/penable     | paddr / pwdata / prdata
//
// One pixel per cycle unless the output stalls; valid runs r_v1..r_v4 to r_vo.
// Stages: offset products, rotated sums and sign fold, two stages of
// restoring division by the cell size, then the index update.
// Synchronous active-low reset empties the pipeline and loads register defaults.
// An output stall freezes every stage at once; the input is stalled only
// while the output register holds a transaction that is stalled.
`timescale 1ns / 1ps
`default_nettype none
module rotated_checker_overlay
    import rco_pkg::*;
#(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire t_pix_in           i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output t_pix_out               o_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    localparam logic signed [OFFS_W-1:0] W_OFF = OFFS_W'(FRAME_WIDTH);
    localparam logic signed [OFFS_W-1:0] H_OFF = OFFS_W'(FRAME_HEIGHT);

    logic signed [TRIG_W-1:0] r_cos, r_sin;
    logic [7:0] r_cell, r_fg, r_light;
    logic [7:0] cs_eff;
    t_reg_idx   reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cs_eff  = (r_cell == 8'd0) ? 8'd1 : r_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos   <= COS_RESET;
            r_sin   <= SIN_RESET;
            r_cell  <= CELL_RESET;
            r_fg    <= FG_RESET;
            r_light <= LIGHT_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_COS_ANGLE:       r_cos   <= pwdata[TRIG_W-1:0];
                REG_SIN_ANGLE:       r_sin   <= pwdata[TRIG_W-1:0];
                REG_CELL_SIZE:       r_cell  <= pwdata[7:0];
                REG_FOREGROUND_BASE: r_fg    <= pwdata[7:0];
                REG_LIGHT_OFFSET:    r_light <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_COS_ANGLE:       prdata = {{(DATA_W-TRIG_W){r_cos[TRIG_W-1]}}, r_cos};
            REG_SIN_ANGLE:       prdata = {{(DATA_W-TRIG_W){r_sin[TRIG_W-1]}}, r_sin};
            REG_CELL_SIZE:       prdata = {24'd0, r_cell};
            REG_FOREGROUND_BASE: prdata = {24'd0, r_fg};
            REG_LIGHT_OFFSET:    prdata = {24'd0, r_light};
            default:             prdata = '0;
        endcase
    end

    // pipeline control
    logic en;
    logic r_v1, r_v2, r_v3, r_v4, r_vo;
    assign en      = !(r_vo && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_vo <= r_v4;
        end
    end

    // stage 1: half-pixel offsets times cos/sin
    logic signed [OFFS_W-1:0] dx2, dy2;
    logic signed [PROD_W-1:0] r_xc, r_xs, r_yc, r_ys;
    logic [7:0] r_idx1, r_idx2, r_idx3, r_idx4;

    assign dx2 = $signed({1'b0, i_data.pixel_x, 1'b1}) - W_OFF;
    assign dy2 = $signed({1'b0, i_data.pixel_y, 1'b1}) - H_OFF;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xc   <= PROD_W'(dx2 * r_cos);
            r_xs   <= PROD_W'(dx2 * r_sin);
            r_yc   <= PROD_W'(dy2 * r_cos);
            r_ys   <= PROD_W'(dy2 * r_sin);
            r_idx1 <= i_data.index_in;
        end
    end

    // stage 2: rotate, floor by 2^15, fold negatives so floor(a/cs) = ~floor(~a/cs)
    logic signed [SUM_W-1:0] us, vs;
    logic signed [CELL_W-1:0] au, av;
    logic [MAG_W-1:0] r_mag_u, r_mag_v;
    logic r_sgn_u2, r_sgn_v2;

    assign us = SUM_W'(r_xc) - SUM_W'(r_ys);
    assign vs = SUM_W'(r_xs) + SUM_W'(r_yc);
    assign au = us[SUM_W-1:FRAC_W];
    assign av = vs[SUM_W-1:FRAC_W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sgn_u2 <= au[CELL_W-1];
            r_sgn_v2 <= av[CELL_W-1];
            r_mag_u  <= au[CELL_W-1] ? ~au[MAG_W-1:0] : au[MAG_W-1:0];
            r_mag_v  <= av[CELL_W-1] ? ~av[MAG_W-1:0] : av[MAG_W-1:0];
            r_idx2   <= r_idx1;
        end
    end

    // stage 3: upper quotient bits, remainder only
    logic [7:0] rem3_u, rem3_v;
    logic [7:0] r_rem_u, r_rem_v;
    logic [DIV_SPLIT-1:0] r_low_u, r_low_v;
    logic r_sgn_u3, r_sgn_v3;

    always_comb begin
        logic [8:0] tu, tv;
        rem3_u = 8'd0;
        rem3_v = 8'd0;
        for (int k = MAG_W - 1; k >= DIV_SPLIT; k--) begin
            tu = {rem3_u, r_mag_u[k]};
            tv = {rem3_v, r_mag_v[k]};
            rem3_u = (tu >= {1'b0, cs_eff}) ? 8'(tu - {1'b0, cs_eff}) : tu[7:0];
            rem3_v = (tv >= {1'b0, cs_eff}) ? 8'(tv - {1'b0, cs_eff}) : tv[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem_u  <= rem3_u;
            r_rem_v  <= rem3_v;
            r_low_u  <= r_mag_u[DIV_SPLIT-1:0];
            r_low_v  <= r_mag_v[DIV_SPLIT-1:0];
            r_sgn_u3 <= r_sgn_u2;
            r_sgn_v3 <= r_sgn_v2;
            r_idx3   <= r_idx2;
        end
    end

    // stage 4: lower quotient bits; the last one gives the parity
    logic [7:0] rem4_u, rem4_v;
    logic q0_u, q0_v;
    logic r_light_cell;

    always_comb begin
        logic [8:0] tu, tv;
        rem4_u = r_rem_u;
        rem4_v = r_rem_v;
        q0_u   = 1'b0;
        q0_v   = 1'b0;
        for (int k = DIV_SPLIT - 1; k >= 0; k--) begin
            tu = {rem4_u, r_low_u[k]};
            tv = {rem4_v, r_low_v[k]};
            q0_u = (tu >= {1'b0, cs_eff});
            q0_v = (tv >= {1'b0, cs_eff});
            rem4_u = q0_u ? 8'(tu - {1'b0, cs_eff}) : tu[7:0];
            rem4_v = q0_v ? 8'(tv - {1'b0, cs_eff}) : tv[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_light_cell <= q0_u ^ r_sgn_u3 ^ q0_v ^ r_sgn_v3;
            r_idx4       <= r_idx3;
        end
    end

    // stage 5: output register
    t_pix_out r_out;
    assign o_data = r_out;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.on_light_cell <= r_light_cell;
            r_out.index_out     <= (r_light_cell && (r_idx4 < r_fg)) ?
                                   8'(r_idx4 + r_light) : r_idx4;
        end
    end

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_vo && i_stall))
        else $error("input stalled without a stalled output transaction");

    a_cell_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cs_eff != 8'd0)
        else $error("effective cell size is zero");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_rem_u < cs_eff) && (r_rem_v < cs_eff))
        else $error("partial remainder not below cell size");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire

/* tb/rco_overlay_checker.sv */
// Checker for the rotated checker overlay: predicts and compares every transaction.
`timescale 1ns / 1ps
module rco_overlay_checker
    import rco_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              o_stall,
    input  wire t_pix_in           i_data,
    input  wire logic              o_valid,
    input  wire logic              i_stall,
    input  wire t_pix_out          o_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    input  wire logic              pready,
    output int                     o_errors,
    output int                     o_pending
);

    logic signed [TRIG_W-1:0] cos_q, sin_q;
    logic [7:0] cell_q, fg_q, light_q;
    t_pix_out overlay_queue[$];

    assign o_pending = overlay_queue.size();

    function automatic longint floor_div(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic t_pix_out overlay_predict(t_pix_in px);
        longint dx2, dy2, cv, sv, us, vs, dv, iu, iv;
        t_pix_out r;
        dx2 = 2 * longint'(px.pixel_x) + 1 - FRAME_WIDTH_DEF;
        dy2 = 2 * longint'(px.pixel_y) + 1 - FRAME_HEIGHT_DEF;
        cv = longint'(cos_q);
        sv = longint'(sin_q);
        us = dx2 * cv - dy2 * sv;
        vs = dx2 * sv + dy2 * cv;
        dv = longint'((cell_q == 8'd0) ? 8'd1 : cell_q) * 32768;
        iu = floor_div(us, dv);
        iv = floor_div(vs, dv);
        r.on_light_cell = ((iu + iv) & 1) != 0;
        r.index_out = px.index_in;
        if (r.on_light_cell && px.index_in < fg_q) r.index_out = px.index_in + light_q;
        return r;
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_pix_out want;
        if (!i_rst_n) begin
            cos_q   <= COS_RESET;
            sin_q   <= SIN_RESET;
            cell_q  <= CELL_RESET;
            fg_q    <= FG_RESET;
            light_q <= LIGHT_RESET;
            overlay_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_COS_ANGLE:       cos_q   <= pwdata[15:0];
                    REG_SIN_ANGLE:       sin_q   <= pwdata[15:0];
                    REG_CELL_SIZE:       cell_q  <= pwdata[7:0];
                    REG_FOREGROUND_BASE: fg_q    <= pwdata[7:0];
                    REG_LIGHT_OFFSET:    light_q <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                if (overlay_queue.size() == 0) begin
                    report("output transaction with nothing expected");
                end else begin
                    want = overlay_queue.pop_front();
                    if (o_data.index_out !== want.index_out)
                        report($sformatf("index_out %0h, want %0h",
                                         o_data.index_out, want.index_out));
                    if (o_data.on_light_cell !== want.on_light_cell)
                        report($sformatf("on_light_cell %0b, want %0b",
                                         o_data.on_light_cell, want.on_light_cell));
                end
            end
            if (i_valid && !o_stall) overlay_queue.push_back(overlay_predict(i_data));
        end
    end

endmodule

/* tb/rotated_checker_overlay_test.sv */
// Stimulus and verdict for the rotated checker overlay.
`timescale 1ns / 1ps
module rotated_checker_overlay_test;
    import rco_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_pix_in i_data = '0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic o_stall, o_valid, pready;
    t_pix_out o_data;
    logic [DATA_W-1:0] prdata;
    int errors, pending, cycles = 0;
    bit quiet = 1'b0;
    bit gaps = 1'b1;
    int stall_left = 0;

    always #5 i_clk = ~i_clk;

    rotated_checker_overlay DUT (.*);

    rco_overlay_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data, .o_valid, .i_stall, .o_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver idling: random stall bursts, none in the quiet tail.
    always @(negedge i_clk) begin
        if (quiet) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (i_stall) begin
            i_stall <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(0, 11);
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every transaction has left the block.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic set_all(int c, int s, int cs, int fg, int lo);
        drain();
        reg_write(REG_COS_ANGLE, c);
        reg_write(REG_SIN_ANGLE, s);
        reg_write(REG_CELL_SIZE, cs);
        reg_write(REG_FOREGROUND_BASE, fg);
        reg_write(REG_LIGHT_OFFSET, lo);
    endtask

    // Called at a falling edge; returns at a falling edge after acceptance.
    task automatic send(logic [9:0] x, logic [9:0] y, logic [7:0] idx);
        i_valid <= 1'b1;
        i_data <= '{pixel_x: x, pixel_y: y, index_in: idx};
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        @(negedge i_clk);
        if (gaps && !quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    task automatic send_random();
        logic [9:0] x, y;
        if ($urandom_range(0, 3) == 0) begin
            x = 10'($urandom); y = 10'($urandom);
        end else begin
            x = 10'($urandom_range(0, FRAME_WIDTH_DEF - 1));
            y = 10'($urandom_range(0, FRAME_HEIGHT_DEF - 1));
        end
        send(x, y, 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom));
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: corners, centre, out-of-frame, index extremes.
        send(0, 0, 0);
        send(1023, 1023, 255);
        send(159, 99, 3);
        send(160, 100, 4);
        send(319, 199, 1);
        send(1023, 0, 0);
        send(0, 1023, 2);

        // Extreme angle, zero cell size, and ignored register addresses.
        set_all(32'hFFFF_8000, 32'h0000_7FFF, 0, 255, 255);
        reg_write(3'd5, 32'hFFFF_FFFF);
        reg_write(3'd6, 32'h0);
        reg_write(3'd7, 32'h1234_5678);
        send(0, 0, 0);
        send(1023, 1023, 254);
        send(170, 33, 255);
        send(512, 600, 7);
        send(161, 101, 128);

        set_all(-16384, 16384, 1, 0, 0);
        send(0, 0, 0);
        send(1023, 511, 100);
        send(160, 100, 255);

        set_all(11585, -11585, 255, 128, 200);
        send(0, 0, 100);
        send(1023, 1023, 127);
        send(700, 800, 0);

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0) set_all(16384, 0, 24, 4, 2);
            else set_all($urandom, $urandom,
                         ph % 3 == 0 ? $urandom : $urandom_range(0, 16),
                         $urandom, $urandom);
            if (ph == 7) begin
                drain();
                quiet = 1'b1;
            end
            repeat (130) send_random();
        end

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule
